/* rtl/psgdma_pkg.sv */
// ----------------------------------------------------------------------------
// psgdma_pkg: shared types and constants for the sound-chip audio bridge
// Payload structs, sequencer states and the poly gate tables.
// ----------------------------------------------------------------------------
package psgdma_pkg;

   localparam int unsigned NOISE_WORDS = 512;
   localparam logic [21:0] CLK_SRC     = 22'd1789773;
   localparam logic [21:0] CLK_DST     = 22'd3546895;
   localparam logic [15:0] PER_MIN     = 16'd124;
   localparam logic [21:0] FREQ_MAX    = 22'd28000;
   localparam logic [21:0] FREQ_MIN    = 22'd50;
   localparam logic [16:0] LFSR_RESET  = 17'h1FFFF;
   localparam logic [3:0]  OFF_CTL     = 4'd8;
   localparam logic [3:0]  OFF_RANDOM  = 4'd10;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [1:0] SRC_SQUARE = 2'd0;
   localparam logic [1:0] SRC_NOISE  = 2'd1;
   localparam logic [1:0] SRC_POLY   = 2'd2;

   localparam logic [14:0] GATE4 = 15'b010110010001111;
   localparam logic [30:0] GATE5 = 31'b0101000100111000001100101101111;

   typedef struct packed {
      logic       opcode;
      logic [3:0] reg_offset;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  read_data;
      logic [1:0]  channel;
      logic [15:0] period;
      logic        period_write;
      logic [5:0]  volume;
      logic [1:0]  wave_source;
      logic [9:0]  wave_length_words;
      logic        wave_buffer;
      logic [61:0] wave_bits;
      logic        noise_active;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV1_INIT,
      ST_DIV1,
      ST_DIV2_INIT,
      ST_DIV2,
      ST_FINISH,
      ST_POLY,
      ST_EMIT,
      ST_OUT
   } state_type;

endpackage

/* rtl/psg_to_dma_audio_bridge.sv */
// ----------------------------------------------------------------------------
// psg_to_dma_audio_bridge: sound-chip register window to DMA audio updates
// Shadows 16 registers, serves reads and derives channel updates on writes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  req     | in  | req_valid/req_ready | psgdma_pkg::req_type
//  rsp     | out | rsp_valid/rsp_ready | psgdma_pkg::rsp_type
//
//  A read word is valid on rsp the cycle after acceptance. A control write
//  updates all four channels. Each update runs a 22-step restoring division,
//  a second one if the frequency is in range, on one shared subtract unit,
//  and 30 or 62 pattern steps for poly. Writes to offsets 9..15 give no word.
//  Reset is synchronous; it clears shadow and ping-pong bits, presets the LFSR.
//  req_ready is low while a word is in work; a held rsp stalls the sequencer.
module psg_to_dma_audio_bridge (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psgdma_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output psgdma_pkg::rsp_type rsp_data
);

   psgdma_pkg::state_type state_ff, state_in;
   logic [7:0]  shadow_ff [16];
   logic [16:0] lfsr_ff;
   logic [3:0]  pp_ff;
   logic [1:0]  ch_ff;
   logic        all_ff;
   logic [22:0] rem_ff;
   logic [21:0] quo_ff;
   logic [22:0] dsr_ff;
   logic [4:0]  cnt_ff;
   logic        silent_ff;
   logic [15:0] per_ff;
   logic [3:0]  s4_ff, c4_ff;
   logic [4:0]  s5_ff, c5_ff;
   logic        lvl_ff;
   logic [61:0] bits_ff;
   logic [5:0]  idx_ff;
   psgdma_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;

   logic [7:0]  audf, audc, ctl, audf_nx;
   logic [6:0]  base;
   logic        fast, chain, noise, p5, p4, poly;
   logic [16:0] divv;
   logic [23:0] rem_sh;
   logic [23:0] trial;
   logic        fits;
   logic        freq_ok;
   logic [15:0] per_raw, per_nx;
   logic [8:0]  audf_p1;
   logic [14:0] stride;
   logic [6:0]  f15a, f15b, f31a, f31b;
   logic [3:0]  s4_nx;
   logic [4:0]  s5_nx;
   logic [4:0]  sum4;
   logic [5:0]  sum5;
   logic [3:0]  c4_nx;
   logic [4:0]  c5_nx;
   logic        flip, lvl_nx;
   logic [16:0] lfsr_nx;
   logic [5:0]  vol;
   logic [5:0]  npoly;
   logic        start;
   psgdma_pkg::rsp_type rd_word, upd_word;

   assign audf    = shadow_ff[{1'b0, ch_ff, 1'b0}];
   assign audc    = shadow_ff[{1'b0, ch_ff, 1'b1}];
   assign ctl     = shadow_ff[psgdma_pkg::OFF_CTL];
   assign audf_nx = shadow_ff[{1'b0, ch_ff + 2'd1, 1'b0}];
   assign base    = ctl[0] ? 7'd114 : 7'd28;
   assign fast    = (ch_ff == 2'd0 && ctl[5]) || (ch_ff == 2'd2 && ctl[6]);
   assign chain   = (ch_ff == 2'd0 && ctl[3]) || (ch_ff == 2'd2 && ctl[4]);
   assign divv    = {1'b0, chain ? audf_nx : 8'd0, audf} + 17'd1;
   assign noise   = !audc[5] && !audc[6] && !audc[4];
   assign p5      = audc[5] && !audc[7];
   assign p4      = !audc[5] && audc[6];
   assign poly    = p4 || p5;
   assign npoly   = p4 ? 6'd30 : 6'd62;
   assign start   = req_valid && req_ready;
   assign lfsr_nx = {lfsr_ff[15:0], lfsr_ff[16] ^ lfsr_ff[4]};

   // shared unit: shift remainder in one quotient bit, trial subtract
   assign rem_sh  = {rem_ff, quo_ff[21]};
   assign fits    = rem_sh >= {1'b0, dsr_ff};
   assign trial   = rem_sh - {1'b0, dsr_ff};

   assign freq_ok = (quo_ff >= psgdma_pkg::FREQ_MIN) && (quo_ff <= psgdma_pkg::FREQ_MAX);

   always_comb begin
      if (silent_ff) begin
         per_raw = 16'd0;
      end else if (quo_ff[21:16] != 6'd0) begin
         per_raw = 16'hFFFF;
      end else if (quo_ff[15:0] < psgdma_pkg::PER_MIN) begin
         per_raw = psgdma_pkg::PER_MIN;
      end else begin
         per_raw = quo_ff[15:0];
      end
      per_nx = (noise && per_raw == 16'd0) ? psgdma_pkg::PER_MIN : per_raw;
   end

   // stride mod 15 and mod 31 by folding digits
   assign audf_p1 = {1'b0, audf} + 9'd1;
   assign stride  = 15'({7'd0, audf_p1} * {9'd0, base});
   assign f15a    = 7'(stride[14:12]) + 7'(stride[11:8]) + 7'(stride[7:4]) + 7'(stride[3:0]);
   assign f15b    = 7'(f15a[6:4]) + 7'(f15a[3:0]);
   assign s4_nx   = (f15b >= 7'd15) ? 4'(f15b - 7'd15) : f15b[3:0];
   assign f31a    = 7'(stride[14:10]) + 7'(stride[9:5]) + 7'(stride[4:0]);
   assign f31b    = 7'(f31a[6:5]) + 7'(f31a[4:0]);
   assign s5_nx   = (f31b >= 7'd31) ? 5'(f31b - 7'd31) : f31b[4:0];

   assign sum4   = {1'b0, c4_ff} + {1'b0, s4_ff};
   assign c4_nx  = (sum4 >= 5'd15) ? 4'(sum4 - 5'd15) : sum4[3:0];
   assign sum5   = {1'b0, c5_ff} + {1'b0, s5_ff};
   assign c5_nx  = (sum5 >= 6'd31) ? 5'(sum5 - 6'd31) : sum5[4:0];
   assign flip   = p4 ? (psgdma_pkg::GATE4[c4_nx] == !lvl_ff) : psgdma_pkg::GATE5[c5_nx];
   assign lvl_nx = lvl_ff ^ flip;

   always_comb begin
      vol = audc[4] ? 6'd0 : {audc[3:0], 2'b00};
      if (!noise && per_ff == 16'd0) begin
         vol = 6'd0;
      end
   end

   always_comb begin
      rd_word      = '0;
      rd_word.last = 1'b1;
      if (req_data.reg_offset == psgdma_pkg::OFF_RANDOM) begin
         rd_word.read_data = lfsr_nx[7:0];
      end else begin
         rd_word.read_data = shadow_ff[req_data.reg_offset];
      end
   end

   always_comb begin
      upd_word                   = '0;
      upd_word.result_kind       = 1'b1;
      upd_word.channel           = ch_ff;
      upd_word.period            = per_ff;
      upd_word.period_write      = per_ff != 16'd0;
      upd_word.volume            = vol;
      upd_word.noise_active      = noise && vol != 6'd0;
      upd_word.last              = !all_ff || ch_ff == 2'd3;
      upd_word.wave_source       = psgdma_pkg::SRC_SQUARE;
      upd_word.wave_length_words = 10'd1;
      if (noise) begin
         upd_word.wave_source       = psgdma_pkg::SRC_NOISE;
         upd_word.wave_length_words = 10'(psgdma_pkg::NOISE_WORDS);
      end else if (poly) begin
         upd_word.wave_source       = psgdma_pkg::SRC_POLY;
         upd_word.wave_length_words = p4 ? 10'd15 : 10'd31;
         upd_word.wave_buffer       = !pp_ff[ch_ff];
         upd_word.wave_bits         = bits_ff;
      end
   end

   always_comb begin
      req_ready = (state_ff == psgdma_pkg::ST_IDLE) && !rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psgdma_pkg::ST_IDLE: begin
            if (start && req_data.opcode == psgdma_pkg::OP_READ) begin
               state_in = psgdma_pkg::ST_OUT;
            end else if (start && (!req_data.reg_offset[3]
                                   || req_data.reg_offset == psgdma_pkg::OFF_CTL)) begin
               state_in = psgdma_pkg::ST_DIV1_INIT;
            end
         end
         psgdma_pkg::ST_DIV1_INIT: state_in = psgdma_pkg::ST_DIV1;
         psgdma_pkg::ST_DIV1: begin
            if (cnt_ff == 5'd21) state_in = psgdma_pkg::ST_DIV2_INIT;
         end
         psgdma_pkg::ST_DIV2_INIT: begin
            state_in = freq_ok ? psgdma_pkg::ST_DIV2 : psgdma_pkg::ST_FINISH;
         end
         psgdma_pkg::ST_DIV2: begin
            if (cnt_ff == 5'd21) state_in = psgdma_pkg::ST_FINISH;
         end
         psgdma_pkg::ST_FINISH: begin
            state_in = poly ? psgdma_pkg::ST_POLY : psgdma_pkg::ST_EMIT;
         end
         psgdma_pkg::ST_POLY: begin
            if (idx_ff == npoly - 6'd1) state_in = psgdma_pkg::ST_EMIT;
         end
         psgdma_pkg::ST_EMIT: state_in = psgdma_pkg::ST_OUT;
         psgdma_pkg::ST_OUT: begin
            if (rsp_valid_ff && rsp_ready) begin
               state_in = (rsp_ff.result_kind && !rsp_ff.last)
                        ? psgdma_pkg::ST_DIV1_INIT : psgdma_pkg::ST_IDLE;
            end
         end
         default: state_in = psgdma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psgdma_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lfsr_ff      <= psgdma_pkg::LFSR_RESET;
         pp_ff        <= '0;
         for (int i = 0; i < 16; i++) shadow_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            psgdma_pkg::ST_IDLE: begin
               if (start) begin
                  if (req_data.opcode == psgdma_pkg::OP_READ) begin
                     rsp_ff       <= rd_word;
                     rsp_valid_ff <= 1'b1;
                     if (req_data.reg_offset == psgdma_pkg::OFF_RANDOM) begin
                        lfsr_ff <= lfsr_nx;
                     end
                  end else begin
                     shadow_ff[req_data.reg_offset] <= req_data.write_data;
                     ch_ff  <= req_data.reg_offset[3] ? 2'd0 : req_data.reg_offset[2:1];
                     all_ff <= req_data.reg_offset[3];
                  end
               end
            end
            psgdma_pkg::ST_DIV1_INIT: begin
               // freq = CLK_SRC / (base*div) or CLK_SRC / div
               rem_ff <= '0;
               quo_ff <= psgdma_pkg::CLK_SRC;
               dsr_ff <= fast ? {6'd0, divv} : 23'({6'd0, divv} * {16'd0, base});
               cnt_ff <= '0;
            end
            psgdma_pkg::ST_DIV1, psgdma_pkg::ST_DIV2: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (fits) begin
                  rem_ff <= trial[22:0];
                  quo_ff <= {quo_ff[20:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[22:0];
                  quo_ff <= {quo_ff[20:0], 1'b0};
               end
            end
            psgdma_pkg::ST_DIV2_INIT: begin
               // per = CLK_DST / (2*freq); out-of-range freq is silent unless on noise
               rem_ff    <= '0;
               quo_ff    <= psgdma_pkg::CLK_DST;
               dsr_ff    <= {quo_ff, 1'b0};
               cnt_ff    <= '0;
               silent_ff <= !freq_ok;
            end
            psgdma_pkg::ST_FINISH: begin
               per_ff  <= per_nx;
               s4_ff   <= s4_nx;
               s5_ff   <= s5_nx;
               idx_ff  <= '0;
               c4_ff   <= '0;
               c5_ff   <= '0;
               lvl_ff  <= 1'b0;
               bits_ff <= '0;
            end
            psgdma_pkg::ST_POLY: begin
               idx_ff  <= idx_ff + 6'd1;
               c4_ff   <= c4_nx;
               c5_ff   <= c5_nx;
               lvl_ff  <= lvl_nx;
               bits_ff[idx_ff] <= lvl_nx;
            end
            psgdma_pkg::ST_EMIT: begin
               rsp_ff       <= upd_word;
               rsp_valid_ff <= 1'b1;
               if (!noise && poly) begin
                  pp_ff[ch_ff] <= !pp_ff[ch_ff];
               end
            end
            psgdma_pkg::ST_OUT: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  ch_ff        <= ch_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
